[design/tcce_pkg.sv]
// shared constants, payload structs and control/status types for the console engine
package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int ROW_W      = $clog2(ROWS + 1);

  localparam logic [1:0] FN_PUT   = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_LAST    = 8'd127;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_PUT   = 2'd1;
  localparam logic [1:0] WR_BLANK = 2'd2;
  localparam logic [1:0] WR_COPY  = 2'd3;

  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_ZERO = 2'd1;
  localparam logic [1:0] CNT_INC  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        scrolled;
  } res_t;

  typedef struct packed {
    logic       capture;
    logic       rd_en;
    logic       rd_copy;
    logic [1:0] wr_src;
    logic       put_step;
    logic       cur_home;
    logic [1:0] cnt_ctl;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       overflow;
    logic       cnt_zero;
    logic       cnt_copy_end;
    logic       cnt_last;
    logic       res_free;
  } sts_t;

endpackage

[design/text_console_cursor_engine.sv]
// top level of the text console engine: controller and datapath
//
//  channel  | direction | handshake             | payload
//  request  | in        | req_valid / req_stall | req_data (req_t)
//  result   | out       | res_valid / res_stall | res_data (res_t)
//  config   | in        | cfg_valid / cfg_ready | cfg_data (attribute byte)
//
// put without scroll and read: exec, then done loads the result once res_free is high
// a put that scrolls first copies every row up by one row, then blanks the bottom row
// clear blanks every cell, one memory port write per cycle
// after reset every cell of the screen is blanked with req_stall high
// a new request is taken while the previous result waits under res_stall
module text_console_cursor_engine import tcce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req_data,
  output logic       res_valid,
  input  logic       res_stall,
  output res_t       res_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcce_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_data  (res_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[design/tcce_ctrl.sv]
// sequencing state machine: request intake, put/read/clear steps, scroll and fill sweeps
module tcce_ctrl import tcce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_BLANK  = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_src  = WR_NONE;
    cmd.cnt_ctl = CNT_HOLD;
    case (state)
      S_INIT, S_FILL: begin
        cmd.wr_src  = WR_BLANK;
        cmd.cnt_ctl = CNT_INC;
        if (sts.cnt_last) begin
          cmd.cnt_ctl = CNT_ZERO;
          state_next  = (state == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.rd_en   = 1'b1;
        cmd.cnt_ctl = CNT_ZERO;
        if (sts.func == FN_PUT) begin
          cmd.wr_src   = WR_PUT;
          cmd.put_step = 1'b1;
          state_next   = sts.overflow ? S_SCROLL : S_DONE;
        end else if (sts.func == FN_CLEAR) begin
          cmd.cur_home = 1'b1;
          state_next   = S_FILL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCROLL: begin
        // read one row ahead, write each read back one row up in the next cycle
        cmd.rd_en   = !sts.cnt_copy_end;
        cmd.rd_copy = 1'b1;
        cmd.wr_src  = sts.cnt_zero ? WR_NONE : WR_COPY;
        if (sts.cnt_copy_end) begin
          cmd.cnt_ctl = CNT_HOLD;
          state_next  = S_BLANK;
        end else begin
          cmd.cnt_ctl = CNT_INC;
        end
      end
      S_BLANK: begin
        cmd.wr_src  = WR_BLANK;
        cmd.cnt_ctl = CNT_INC;
        if (sts.cnt_last) begin
          cmd.cnt_ctl = CNT_ZERO;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.res_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

[design/tcce_datapath.sv]
// cursor registers, screen memory, sweep counter, attribute register and result register
module tcce_datapath import tcce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req_data,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       res_stall,
  output logic       res_valid,
  output res_t       res_data,
  input  cmd_t       cmd,
  output sts_t       sts
);

  logic [15:0]       mem [CELL_COUNT];
  req_t              req_q;
  logic [7:0]        attr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              scroll_q;
  logic [ADDR_W-1:0] cnt;
  logic [15:0]       rd_data;

  logic [COL_W-1:0]  col_s;
  logic [COL_W-1:0]  col_w;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_s;
  logic [ROW_W-1:0]  row_next;
  logic              overflow;
  logic              put_wr;
  logic [15:0]       put_data;
  logic [ADDR_W-1:0] put_addr;
  logic [ADDR_W-1:0] here_addr;
  logic [15:0]       blank;
  logic              in_range;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       res_cell;

  assign blank     = {attr, CH_SPACE};
  assign here_addr = ADDR_W'(row * COLUMNS + col);
  assign in_range  = 32'(req_q.cell_index) < CELL_COUNT;

  // character step, then right edge wrap, then bottom edge
  always_comb begin
    col_s    = col;
    row_s    = row;
    col_w    = col;
    put_wr   = 1'b0;
    put_data = blank;
    case (req_q.char_code)
      CH_LF: begin
        row_s = row + 1'b1;
        col_s = '0;
      end
      CH_CR: begin
        col_s = '0;
      end
      CH_BS: begin
        if (col != '0) begin
          col_s = col - 1'b1;
        end
        col_w  = col_s;
        put_wr = 1'b1;
      end
      default: begin
        if (req_q.char_code inside {[CH_SPACE:CH_LAST]}) begin
          put_wr   = 1'b1;
          put_data = {attr, req_q.char_code};
          col_s    = col + 1'b1;
        end
      end
    endcase
    put_addr = ADDR_W'(row * COLUMNS + col_w);
    col_next = col_s;
    row_next = row_s;
    if (col_s == COL_W'(COLUMNS)) begin
      col_next = '0;
      row_next = row_s + 1'b1;
    end
    overflow = (row_next >= ROW_W'(ROWS));
    if (overflow) begin
      row_next = ROW_W'(ROWS - 1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = blank;
    case (cmd.wr_src)
      WR_PUT: begin
        wr_en   = put_wr;
        wr_addr = put_addr;
        wr_data = put_data;
      end
      WR_BLANK: begin
        wr_en = 1'b1;
      end
      WR_COPY: begin
        wr_en   = 1'b1;
        wr_addr = cnt - 1'b1;
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = cmd.rd_copy ? ADDR_W'(cnt + COLUMNS)
                               : (in_range ? ADDR_W'(req_q.cell_index) : '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr     <= ATTR_RESET;
      col      <= '0;
      row      <= '0;
      scroll_q <= 1'b0;
      cnt      <= '0;
    end else begin
      if (cfg_write) begin
        attr <= cfg_data;
      end
      if (cmd.capture) begin
        scroll_q <= 1'b0;
      end else if (cmd.put_step) begin
        scroll_q <= overflow;
      end
      if (cmd.cur_home) begin
        col <= '0;
        row <= '0;
      end else if (cmd.put_step) begin
        col <= col_next;
        row <= row_next;
      end
      case (cmd.cnt_ctl)
        CNT_ZERO: cnt <= '0;
        CNT_INC:  cnt <= cnt + 1'b1;
        default:  cnt <= cnt;
      endcase
    end
  end

  assign res_cell = (req_q.func == FN_READ && in_range) ? rd_data : 16'd0;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_data.cursor_position <= 11'(here_addr);
      res_data.cell_data       <= res_cell;
      res_data.scrolled        <= scroll_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  assign sts.func         = req_q.func;
  assign sts.overflow     = overflow;
  assign sts.cnt_zero     = (cnt == '0);
  assign sts.cnt_copy_end = (cnt == ADDR_W'(CELL_COUNT - COLUMNS));
  assign sts.cnt_last     = (cnt == ADDR_W'(CELL_COUNT - 1));
  assign sts.res_free     = !res_valid || !res_stall;

endmodule

[design/tcce_checker.sv]
// port-level checks on the console engine and their bind
module tcce_checker import tcce_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic       res_valid,
  input logic       res_stall,
  input res_t       res_data
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result dropped or changed while stalled");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during screen blanking after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous request still in work");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> 32'(res_data.cursor_position) < CELL_COUNT)
    else $error("cursor outside the screen");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.scrolled
      |-> 32'(res_data.cursor_position) >= (ROWS - 1) * COLUMNS)
    else $error("scroll reported with cursor above the bottom row");

endmodule

bind text_console_cursor_engine tcce_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);
